>>> hw/rtl/lcpf_pkg.sv
// ----------------------------------------------------------------------------
// lcpf_pkg
// Shared constants and fixed-point helpers for the LSTM pointwise forward block.
// ----------------------------------------------------------------------------
package lcpf_pkg;

	localparam int unsigned CELLS_DEF     = 4096;
	localparam int unsigned FRAC_BITS_DEF = 12;
	localparam int unsigned IDX_W         = 12;
	localparam int unsigned VAL_W         = 16;
	localparam int unsigned HID_W         = 14;

	typedef logic signed [VAL_W-1:0] val_t;

	// saturating add of two 16-bit values
	function automatic val_t sat_add(input val_t a, input val_t b);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s > 17'sd32767)
			sat_add = 16'sh7fff;
		else if (s < -17'sd32768)
			sat_add = 16'sh8000;
		else
			sat_add = s[VAL_W-1:0];
	endfunction

endpackage

>>> hw/rtl/lcpf_act.sv
// ----------------------------------------------------------------------------
// lcpf_act
// Piecewise-linear sigmoid; with TANH set, computes 2*sigmoid(2x)-1.
// ----------------------------------------------------------------------------
module lcpf_act #(
	parameter int unsigned FRAC_BITS = lcpf_pkg::FRAC_BITS_DEF,
	parameter bit          TANH      = 1'b0
) (
	input  logic signed [lcpf_pkg::VAL_W-1:0] x,
	output logic signed [lcpf_pkg::VAL_W+1:0] y
);
	import lcpf_pkg::*;

	localparam int W = VAL_W + 2;
	localparam logic signed [W-1:0] ONE  = W'(1) <<< FRAC_BITS;
	localparam logic signed [W-1:0] T5   = W'(5 * (1 << FRAC_BITS));
	localparam logic signed [W-1:0] T19  = W'((19 * (1 << FRAC_BITS)) >> 3);
	localparam logic signed [W-1:0] C27  = W'((27 * (1 << FRAC_BITS)) >> 5);
	localparam logic signed [W-1:0] C5   = W'((5 * (1 << FRAC_BITS)) >> 3);
	localparam logic signed [W-1:0] HALF = W'((1 << FRAC_BITS) >> 1);

	logic signed [W-1:0] xs, a, s, r;

	always_comb begin
		xs = TANH ? (W'(x) <<< 1) : W'(x);
		a  = xs[W-1] ? -xs : xs;
		if (a >= T5)
			s = ONE;
		else if (a >= T19)
			s = (a >>> 5) + C27;
		else if (a >= ONE)
			s = (a >>> 3) + C5;
		else
			s = (a >>> 2) + HALF;
		r = xs[W-1] ? ONE - s : s;
		y = TANH ? ((r <<< 1) - ONE) : r;
	end
endmodule

>>> hw/rtl/lcpf_store.sv
// ----------------------------------------------------------------------------
// lcpf_store
// Per-cell state memory: one write port, one synchronous read port.
// ----------------------------------------------------------------------------
module lcpf_store #(
	parameter int unsigned CELLS = lcpf_pkg::CELLS_DEF,
	parameter int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
	input  logic                              clk,
	input  logic                              rd_en,
	input  logic [AW-1:0]                     rd_addr,
	output logic signed [lcpf_pkg::VAL_W-1:0] rd_data,
	input  logic                              wr_en,
	input  logic [AW-1:0]                     wr_addr,
	input  logic signed [lcpf_pkg::VAL_W-1:0] wr_data
);
	import lcpf_pkg::*;

	val_t mem [CELLS];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end
endmodule

>>> hw/rtl/lstm_cell_pointwise_forward.sv
// ----------------------------------------------------------------------------
// lstm_cell_pointwise_forward
// LSTM element-wise cell update with per-cell state memory.
// ----------------------------------------------------------------------------
// Takes one item per cycle while no result is stalled. Its result is
// presented in the output register, where it holds until taken. A
// stalled result holds the whole pipeline. Gate sums and
// activations are evaluated as the item is taken and registered together
// with the read of the previous cell value from the state memory. Stage 1
// selects the previous cell value and forms the gate products; stage 2
// rounds and saturates c and writes it back; stage 3 takes tanh(c) and
// forms o*tanh(c) into the output register. A write-back to the same cell
// still in flight is forwarded to stage 1. A cell index beyond the memory
// depth wraps. The state memory needs no clearing pass after reset.
module lstm_cell_pointwise_forward #(
	parameter int unsigned CELLS     = lcpf_pkg::CELLS_DEF,
	parameter int unsigned FRAC_BITS = lcpf_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lcpf_pkg::IDX_W-1:0]         cell_index,
	input  logic                               first_step,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  x_input_gate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  x_forget_gate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  x_candidate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  x_output_gate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  h_input_gate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  h_forget_gate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  h_candidate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  h_output_gate,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [lcpf_pkg::IDX_W-1:0]         out_index,
	output logic signed [lcpf_pkg::HID_W-1:0]  hidden_value,
	output logic signed [lcpf_pkg::VAL_W-1:0]  cell_value
);
	import lcpf_pkg::*;

	localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int AX = VAL_W + 2;
	localparam int PW = 2 * AX + 1;
	localparam logic signed [PW-1:0] RND = PW'((1 << FRAC_BITS) >> 1);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 4 is the output register; pipeline stalls as a whole
	assign adv      = !v_s4 || out_ready;
	assign in_ready = adv;

	logic [AW-1:0] addr_in;
	if (CELLS >= (1 << IDX_W)) begin : g_addr_wide
		assign addr_in = AW'(cell_index);
	end else if ((CELLS & (CELLS - 1)) == 0) begin : g_addr_mask
		assign addr_in = AW'(cell_index & IDX_W'(CELLS - 1));
	end else begin : g_addr_fold
		logic [IDX_W-1:0]   rem;
		logic [2*IDX_W-1:0] mult;
		always_comb begin
			rem  = cell_index;
			mult = '0;
			for (int k = IDX_W - 1; k >= 0; k--) begin
				mult = (2*IDX_W)'(CELLS) << k;
				if ((2*IDX_W)'(rem) >= mult)
					rem = rem - IDX_W'(mult);
			end
		end
		assign addr_in = AW'(rem);
	end

	logic signed [AX-1:0] ig_c, fg_c, gg_c, og_c;
	lcpf_act #(.FRAC_BITS(FRAC_BITS), .TANH(1'b0)) u_ig (
		.x(sat_add(x_input_gate, h_input_gate)), .y(ig_c));
	lcpf_act #(.FRAC_BITS(FRAC_BITS), .TANH(1'b0)) u_fg (
		.x(sat_add(x_forget_gate, h_forget_gate)), .y(fg_c));
	lcpf_act #(.FRAC_BITS(FRAC_BITS), .TANH(1'b1)) u_gg (
		.x(sat_add(x_candidate, h_candidate)), .y(gg_c));
	lcpf_act #(.FRAC_BITS(FRAC_BITS), .TANH(1'b0)) u_og (
		.x(sat_add(x_output_gate, h_output_gate)), .y(og_c));

	// stage 1
	logic [IDX_W-1:0]     idx_s1, idx_s2, idx_s3;
	logic [AW-1:0]        addr_s1, addr_s2;
	logic                 first_s1;
	logic signed [AX-1:0] ig_s1, fg_s1, gg_s1, og_s1, og_s2, og_s3;

	val_t rd_data;
	val_t c_new;
	logic wr_en;
	logic [AW-1:0] wr_addr;

	lcpf_store #(.CELLS(CELLS), .AW(AW)) u_store (
		.clk(clk), .rd_en(adv), .rd_addr(addr_in), .rd_data(rd_data),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(c_new));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	// stage 2 and 3 bookkeeping for forwarding
	logic [AW-1:0] addr_s3;
	val_t c_s4;
	logic [AW-1:0] addr_s4;
	logic signed [PW-1:0] fc_s2, ig_g_s2;
	val_t cprev;

	// forward the newest in-flight value of the same cell
	always_comb begin
		if (first_s1)
			cprev = '0;
		else if (v_s2 && addr_s2 == addr_s1)
			cprev = c_new;
		else if (v_s3 && addr_s3 == addr_s1)
			cprev = c_s4;
		else
			cprev = rd_data;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= cell_index; addr_s1 <= addr_in; first_s1 <= first_step;
			ig_s1 <= ig_c; fg_s1 <= fg_c; gg_s1 <= gg_c; og_s1 <= og_c;
			fc_s2   <= PW'(fg_s1) * PW'(cprev);
			ig_g_s2 <= PW'(ig_s1) * PW'(gg_s1);
			idx_s2 <= idx_s1; addr_s2 <= addr_s1; og_s2 <= og_s1;
			idx_s3 <= idx_s2; addr_s3 <= addr_s2; og_s3 <= og_s2; c_s4 <= c_new;
			addr_s4 <= addr_s3;
		end
	end

	logic signed [PW-1:0] csum, cr;
	always_comb begin
		csum = fc_s2 + ig_g_s2 + RND;
		cr   = csum >>> FRAC_BITS;
		if (cr > PW'(32767))
			c_new = 16'sh7fff;
		else if (cr < -PW'(32768))
			c_new = 16'sh8000;
		else
			c_new = cr[VAL_W-1:0];
	end
	assign wr_en   = adv && v_s2;
	assign wr_addr = addr_s2;

	// stage 3: registered c, tanh(c)
	val_t c_s3;
	logic signed [AX-1:0] tc_c;
	always_ff @(posedge clk) begin
		if (adv)
			c_s3 <= c_new;
	end
	lcpf_act #(.FRAC_BITS(FRAC_BITS), .TANH(1'b1)) u_tc (.x(c_s3), .y(tc_c));

	logic signed [PW-1:0] hp, hr;
	logic signed [HID_W-1:0] h_sat;
	always_comb begin
		hp = (PW'(og_s3) * PW'(tc_c)) + RND;
		hr = hp >>> FRAC_BITS;
		if (hr > PW'(8191))
			h_sat = 14'sh1fff;
		else if (hr < -PW'(8192))
			h_sat = 14'sh2000;
		else
			h_sat = hr[HID_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_index    <= idx_s3;
			hidden_value <= h_sat;
			cell_value   <= c_s3;
		end
	end
	assign out_valid = v_s4;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cell_value))
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> v_s2)
		else $error("write-back without item");
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 |=> v_s4 && cell_value == $past(c_s3))
		else $error("cell value not carried to output");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && adv |=> addr_s4 == $past(addr_s3))
		else $error("address pipeline mismatch");
endmodule

>>> test/lcpf_checker.sv
// ----------------------------------------------------------------------------
// lcpf_checker
// Watches both channels of the LSTM pointwise block, keeps its own copy of the
// per-cell state, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module lcpf_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [lcpf_pkg::IDX_W-1:0]         cell_index,
	input  logic                               first_step,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  x_input_gate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  x_forget_gate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  x_candidate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  x_output_gate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  h_input_gate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  h_forget_gate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  h_candidate,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  h_output_gate,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [lcpf_pkg::IDX_W-1:0]         out_index,
	input  logic signed [lcpf_pkg::HID_W-1:0]  hidden_value,
	input  logic signed [lcpf_pkg::VAL_W-1:0]  cell_value,
	output int                                 fail_count,
	output int                                 pending
);

	localparam longint ONE = 64'sd1 << lcpf_pkg::FRAC_BITS_DEF;

	typedef struct packed {
		logic [lcpf_pkg::IDX_W-1:0]        index;
		logic signed [lcpf_pkg::HID_W-1:0] hidden;
		logic signed [lcpf_pkg::VAL_W-1:0] c_value;
	} lstm_result_t;

	lstm_result_t                      expected_results[$];
	logic signed [lcpf_pkg::VAL_W-1:0] cell_mem[lcpf_pkg::CELLS_DEF];

	assign pending = expected_results.size();

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint sigmoid_fx(longint x);
		longint a, y;
		a = x < 0 ? -x : x;
		if (a >= 5 * ONE)
			y = ONE;
		else if (a >= ((19 * ONE) >>> 3))
			y = (a >>> 5) + ((27 * ONE) >>> 5);
		else if (a >= ONE)
			y = (a >>> 3) + ((5 * ONE) >>> 3);
		else
			y = (a >>> 2) + (ONE >>> 1);
		return x < 0 ? ONE - y : y;
	endfunction

	function automatic longint tanh_fx(longint x);
		return 2 * sigmoid_fx(2 * x) - ONE;
	endfunction

	// arithmetic shift floors, so adding half gives ties toward plus infinity
	function automatic longint round_fx(longint p);
		return (p + (ONE >>> 1)) >>> lcpf_pkg::FRAC_BITS_DEF;
	endfunction

	function automatic longint gate_add(longint a, longint b);
		return clip(a + b, -32768, 32767);
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk) begin
		longint ig, fg, gg, og, cprev, c, h;
		lstm_result_t r, e;
		if (arst_n && in_valid && in_ready) begin
			ig = sigmoid_fx(gate_add(x_input_gate, h_input_gate));
			fg = sigmoid_fx(gate_add(x_forget_gate, h_forget_gate));
			gg = tanh_fx(gate_add(x_candidate, h_candidate));
			og = sigmoid_fx(gate_add(x_output_gate, h_output_gate));
			cprev = first_step ? 0 : longint'(cell_mem[cell_index]);
			c = clip(round_fx(fg * cprev + ig * gg), -32768, 32767);
			h = clip(round_fx(og * tanh_fx(c)), -8192, 8191);
			cell_mem[cell_index] = c[15:0];
			r.index = cell_index;
			r.hidden = h[13:0];
			r.c_value = c[15:0];
			expected_results = {expected_results, r};
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report("unexpected transfer", out_index, 0);
			end else begin
				e = expected_results.pop_front();
				if (out_index !== e.index) report("out_index", out_index, e.index);
				if (hidden_value !== e.hidden) report("hidden_value", hidden_value, e.hidden);
				if (cell_value !== e.c_value) report("cell_value", cell_value, e.c_value);
			end
		end
	end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the LSTM pointwise forward block: directed
// extremes, then random time-step sequences mostly over a small set of cells with
// random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NUM_RANDOM = 530;
	localparam int CYCLE_LIMIT = 200000;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic [lcpf_pkg::IDX_W-1:0]         cell_index;
	logic                               first_step;
	logic signed [lcpf_pkg::VAL_W-1:0]  x_input_gate, x_forget_gate, x_candidate, x_output_gate;
	logic signed [lcpf_pkg::VAL_W-1:0]  h_input_gate, h_forget_gate, h_candidate, h_output_gate;
	logic                               out_valid;
	logic                               out_ready;
	logic [lcpf_pkg::IDX_W-1:0]         out_index;
	logic signed [lcpf_pkg::HID_W-1:0]  hidden_value;
	logic signed [lcpf_pkg::VAL_W-1:0]  cell_value;
	int                                 fail_count;
	int                                 pending;
	int                                 cycles;
	bit                                 written[lcpf_pkg::CELLS_DEF];
	bit                                 long_stall_done;

	lstm_cell_pointwise_forward i_dut (.*);

	lcpf_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic logic signed [15:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(signed'($urandom_range(0, 12000)) - 6000);
			3: return 16'(signed'($urandom_range(0, 50000)) - 25000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send(logic [11:0] idx, logic first, logic signed [15:0] v[8]);
		int gap;
		// an unwritten cell is never read without first_step
		if (!written[idx]) first = 1'b1;
		written[idx] = 1'b1;
		in_valid <= 1'b1;
		cell_index <= idx;
		first_step <= first;
		x_input_gate <= v[0];
		x_forget_gate <= v[1];
		x_candidate <= v[2];
		x_output_gate <= v[3];
		h_input_gate <= v[4];
		h_forget_gate <= v[5];
		h_candidate <= v[6];
		h_output_gate <= v[7];
		do @(posedge clk); while (!in_ready);
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic signed [15:0] v[8];
		logic [11:0] idx;
		in_valid = 1'b0;
		cell_index = '0;
		first_step = 1'b0;
		{x_input_gate, x_forget_gate, x_candidate, x_output_gate} = '0;
		{h_input_gate, h_forget_gate, h_candidate, h_output_gate} = '0;
		@(posedge clk iff arst_n);
		// directed: extremes, saturating sums, regions of the activation
		for (int k = 0; k < 20; k++) begin
			foreach (v[j]) begin
				case (k % 5)
					0: v[j] = 16'sh7fff;
					1: v[j] = 16'sh8000;
					2: v[j] = (j % 2) ? 16'sh7fff : 16'sh8000;
					3: v[j] = 16'(signed'(k * 2300 - 22000));
					default: v[j] = 16'(signed'($urandom_range(0, 8192)) - 4096);
				endcase
			end
			idx = (k < 4) ? 12'hfff : 12'(k % 3);
			send(idx, k == 10, v);
		end
		// random sequences mostly over cells 0 to 15, mostly continuing earlier steps
		for (int n = 0; n < NUM_RANDOM; n++) begin
			foreach (v[j]) v[j] = rand_val();
			idx = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
			send(idx, $urandom_range(0, 15) == 0, v);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		long_stall_done = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!long_stall_done && cycles > 400) begin
				long_stall_done = 1'b1;
				out_ready <= 1'b0;
				repeat (60) @(posedge clk);
			end
			stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

endmodule
